FILE: hdl/cle_pkg.sv
// Shared constants and types for the console line editor.
`default_nettype none
package cle_pkg;

    localparam int MAX_LINE = 256;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 8;
    localparam int LEN_W    = 9;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;
    localparam int LIMIT_W  = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;

    localparam logic REG_LINE_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_LINE);

    typedef struct packed {
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              store_valid;
        logic [IDX_W-1:0]  store_index;
        logic [CHAR_W-1:0] store_char;
        logic              line_done;
        logic [LEN_W-1:0]  line_length;
        logic              last_result;
    } result_t;

    typedef struct packed {
        logic    rubout;
        result_t result;
    } entry_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SPACE,
        PH_LAST
    } phase_t;

endpackage
`default_nettype wire

FILE: hdl/cle_if.sv
// Channel interfaces: received bytes in, editor results out.
`default_nettype none
interface cle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface cle_res_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_char;
    logic       line_done;
    logic [8:0] line_length;
    logic       last_result;

    modport source (
        output valid, output echo_valid, output echo_char, output store_valid,
        output store_index, output store_char, output line_done,
        output line_length, output last_result, input ready
    );
    modport sink (
        input valid, input echo_valid, input echo_char, input store_valid,
        input store_index, input store_char, input line_done,
        input line_length, input last_result, output ready
    );
endinterface
`default_nettype wire

FILE: hdl/cle_front.sv
// Front end: accept bytes, classify them, track the line count, build queue entries.
`default_nettype none
module cle_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    cle_rx_if.sink                            rx,
    input  wire logic [cle_pkg::LIMIT_W-1:0]  line_limit,
    input  wire logic                         q_full,
    output logic                              push,
    output cle_pkg::entry_t                   entry
);
    import cle_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [LIMIT_W-1:0] lim;
    logic [CNT_W:0]     sum;
    logic               is_bs;
    logic               is_nl;

    assign rx.ready = !q_full;
    assign push     = rx.valid && !q_full;

    assign is_bs = (rx.rx_char == CH_BS) || (rx.rx_char == CH_DEL);
    assign is_nl = (rx.rx_char == CH_LF) || (rx.rx_char == CH_CR);
    assign sum   = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        if (line_limit == '0)
        begin
            lim = LIMIT_W'(1);
        end
        else if (line_limit > LIMIT_W'(MAX_LINE))
        begin
            lim = LIMIT_W'(MAX_LINE);
        end
        else
        begin
            lim = line_limit;
        end
    end

    always_comb
    begin
        entry                    = '0;
        entry.result.last_result = 1'b1;
        count_next               = count_reg;
        priority if (is_bs)
        begin
            if (count_reg != '0)
            begin
                entry.rubout = 1'b1;
                count_next   = count_reg - CNT_W'(1);
            end
        end
        else if (is_nl)
        begin
            entry.result.echo_valid  = 1'b1;
            entry.result.echo_char   = (rx.rx_char == CH_CR) ? CH_LF : CH_CR;
            entry.result.store_valid = 1'b1;
            entry.result.store_index = count_reg[IDX_W-1:0];
            entry.result.store_char  = CH_LF;
            entry.result.line_done   = 1'b1;
            entry.result.line_length = LEN_W'(sum);
            count_next               = '0;
        end
        else
        begin
            entry.result.echo_valid  = 1'b1;
            entry.result.echo_char   = rx.rx_char;
            entry.result.store_valid = 1'b1;
            entry.result.store_index = count_reg[IDX_W-1:0];
            entry.result.store_char  = rx.rx_char;
            if (sum >= {{(CNT_W+1-LIMIT_W){1'b0}}, lim})
            begin
                entry.result.line_done   = 1'b1;
                entry.result.line_length = LEN_W'(sum);
                count_next               = '0;
            end
            else
            begin
                count_next = sum[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/cle_queue.sv
// Short FIFO of classified entries between front and back end.
`default_nettype none
module cle_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire cle_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output logic                 empty,
    output cle_pkg::entry_t      head
);
    import cle_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/cle_back.sv
// Back end: expand queue entries into results and hold them in the output register.
`default_nettype none
module cle_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            empty,
    input  wire cle_pkg::entry_t head,
    output logic                 pop,
    cle_res_if.source            res
);
    import cle_pkg::*;

    phase_t  phase_reg;
    phase_t  phase_next;
    result_t res_reg;
    result_t res_next;
    logic    valid_reg;
    logic    valid_next;
    logic    load;
    logic    take;

    assign load = !valid_reg || res.ready;
    assign take = load && !empty;

    always_comb
    begin
        phase_next = phase_reg;
        if (take && head.rubout)
        begin
            unique case (phase_reg)
                PH_FIRST: phase_next = PH_SPACE;
                PH_SPACE: phase_next = PH_LAST;
                PH_LAST:  phase_next = PH_FIRST;
                default:  phase_next = PH_FIRST;
            endcase
        end
    end

    always_comb
    begin
        res_next   = head.result;
        pop        = take;
        valid_next = load ? !empty : valid_reg;
        if (head.rubout)
        begin
            res_next            = '0;
            res_next.echo_valid = 1'b1;
            unique case (phase_reg)
                PH_FIRST:
                begin
                    res_next.echo_char = CH_BS;
                    pop                = 1'b0;
                end
                PH_SPACE:
                begin
                    res_next.echo_char = CH_SP;
                    pop                = 1'b0;
                end
                PH_LAST:
                begin
                    res_next.echo_char   = CH_BS;
                    res_next.last_result = 1'b1;
                end
                default:
                begin
                    res_next.echo_char = CH_BS;
                    pop                = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid       = valid_reg;
    assign res.echo_valid  = res_reg.echo_valid;
    assign res.echo_char   = res_reg.echo_char;
    assign res.store_valid = res_reg.store_valid;
    assign res.store_index = res_reg.store_index;
    assign res.store_char  = res_reg.store_char;
    assign res.line_done   = res_reg.line_done;
    assign res.line_length = res_reg.line_length;
    assign res.last_result = res_reg.last_result;

endmodule
`default_nettype wire

FILE: hdl/console_line_editor.sv
// Console line editor top level: register port, front end, queue and back end.
//
// Usage: received console bytes arrive one transaction at a time on rx
// (valid/ready). Each byte yields one result on res, or three for a
// backspace that rubs out a character (backspace, space, backspace); the
// last result of a byte carries last_result. Results carry the echo byte
// and the line buffer write (index and byte) plus line_done/line_length
// when a line ends by newline or by reaching line_limit.
// A taken byte is queued, then its result is registered in the output register.
// Throughput: rx takes one byte per cycle while the four-entry queue has
// room; res issues one result per cycle while ready, so ordinary bytes
// stream at one per cycle and a rubout occupies the output for three results.
// line_limit sits at APB address 0 (reset 256, 0 acts as 1, above 256
// acts as 256); write it only while the block is idle.
// Reset clears the line count, empties the queue and clears the output valid flag.
// When res stalls, the output register holds its result and the queue
// fills; rx ready drops only once the queue is full.
`default_nettype none
module console_line_editor (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    cle_rx_if.sink                            rx,
    cle_res_if.source                         res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cle_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cle_pkg::DATA_W-1:0]   pwdata,
    output logic      [cle_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);
    import cle_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_wr;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    entry_t             push_entry;
    entry_t             head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LINE_LIMIT);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LINE_LIMIT)
        begin
            prdata = {{(DATA_W-LIMIT_W){1'b0}}, limit_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    cle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .line_limit (limit_reg),
        .q_full     (q_full),
        .push       (push),
        .entry      (push_entry)
    );

    cle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    cle_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

    a_nonlast_is_echo: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last_result |-> res.echo_valid && !res.store_valid)
        else $error("non-final result without echo");

    a_done_length: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.line_done |->
            res.store_valid && (res.line_length == ({1'b0, res.store_index} + 9'd1)))
        else $error("line length does not match store index");

    a_rubout_continues: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && !res.last_result |=> res.valid)
        else $error("rubout sequence broken");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the console line editor: line editing, echo and limit checks.
module tb;
    import cle_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 5000;
    localparam logic [PADDR_W-1:0] ADDR_LINE_LIMIT = PADDR_W'(4 * REG_LINE_LIMIT);
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4);

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cle_rx_if  rx_ch();
    cle_res_if res_ch();

    console_line_editor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    result_t            results_due[$];
    int                 line_count;
    logic [LIMIT_W-1:0] limit_reg;
    int                 mismatches;
    int                 cycles;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_left;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void edit_keystroke(input logic [CHAR_W-1:0] c);
        result_t r;
        int      lim;
        int      idx;
        lim = (limit_reg == 0) ? 1 : ((limit_reg > MAX_LINE) ? MAX_LINE : int'(limit_reg));
        idx = line_count;
        r = '0;
        if (c == CH_BS || c == CH_DEL)
        begin
            if (line_count == 0)
            begin
                r.last_result = 1'b1;
                results_due.push_back(r);
            end
            else
            begin
                line_count--;
                r.echo_valid = 1'b1;
                r.echo_char = CH_BS;
                results_due.push_back(r);
                r.echo_char = CH_SP;
                results_due.push_back(r);
                r.echo_char = CH_BS;
                r.last_result = 1'b1;
                results_due.push_back(r);
            end
        end
        else if (c == CH_LF || c == CH_CR)
        begin
            r.echo_valid = 1'b1;
            r.echo_char = (c == CH_CR) ? CH_LF : CH_CR;
            r.store_valid = 1'b1;
            r.store_index = IDX_W'(idx);
            r.store_char = CH_LF;
            r.line_done = 1'b1;
            r.line_length = LEN_W'(idx + 1);
            r.last_result = 1'b1;
            line_count = 0;
            results_due.push_back(r);
        end
        else
        begin
            line_count = idx + 1;
            r.echo_valid = 1'b1;
            r.echo_char = c;
            r.store_valid = 1'b1;
            r.store_index = IDX_W'(idx);
            r.store_char = c;
            r.last_result = 1'b1;
            if (line_count >= lim)
            begin
                r.line_done = 1'b1;
                r.line_length = LEN_W'(line_count);
                line_count = 0;
            end
            results_due.push_back(r);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with nothing expected: echo_char 0x%0h", res_ch.echo_char);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("echo_valid", want.echo_valid, res_ch.echo_valid);
                check_field("echo_char", want.echo_char, res_ch.echo_char);
                check_field("store_valid", want.store_valid, res_ch.store_valid);
                check_field("store_index", want.store_index, res_ch.store_index);
                check_field("store_char", want.store_char, res_ch.store_char);
                check_field("line_done", want.line_done, res_ch.line_done);
                check_field("line_length", want.line_length, res_ch.line_length);
                check_field("last_result", want.last_result, res_ch.last_result);
            end
        end
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_key(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid = 1'b0;
            @(negedge clk);
        end
        rx_ch.valid = 1'b1;
        rx_ch.rx_char = c;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        edit_keystroke(c);
        @(negedge clk);
    endtask

    task automatic drain();
        rx_ch.valid = 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_LINE_LIMIT)
            limit_reg = data[LIMIT_W-1:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic read_reg(input logic [PADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = addr;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_line_limit();
        logic [DATA_W-1:0] value;
        read_reg(ADDR_LINE_LIMIT, value);
        check_field("line_limit", int'(limit_reg), int'(value));
    endtask

    task automatic set_line_limit(input logic [DATA_W-1:0] value);
        drain();
        write_reg(ADDR_LINE_LIMIT, value);
        check_line_limit();
    endtask

    function automatic logic [CHAR_W-1:0] pick_keystroke();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return CHAR_W'($urandom_range(8'h20, 8'h7E));
        else if (r < 70)
            return $urandom_range(1) ? CH_BS : CH_DEL;
        else if (r < 80)
            return $urandom_range(1) ? CH_CR : CH_LF;
        return CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [DATA_W-1:0] pick_limit();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return DATA_W'($urandom_range(1, 24));
        else if (r < 70)
            return '0;
        else if (r < 80)
            return DATA_W'($urandom_range(MAX_LINE, 511));
        return $urandom();
    endfunction

    task automatic test_directed_edits();
        logic [CHAR_W-1:0] chars[$];
        check_line_limit();
        chars = '{8'h61, 8'h00, 8'hFF, 8'h80, CH_BS, CH_DEL, CH_BS, CH_BS, CH_DEL,
                  CH_CR, 8'h55, 8'hAA, CH_LF};
        foreach (chars[i])
            send_key(chars[i]);
    endtask

    task automatic test_limit_extremes();
        set_line_limit(32'd0);
        send_key(8'h71);
        send_key(CH_CR);
        set_line_limit(32'hFFFF_FFFF);
        send_key(8'h6D);
        send_key(8'h6E);
        send_key(CH_LF);
        set_line_limit(32'd1);
        drain();
        write_reg(ADDR_UNUSED, 32'd7);
        check_line_limit();
        send_key(8'h6B);
        set_line_limit(32'd256);
        for (int i = 0; i < 6; i++)
            send_key(CHAR_W'(8'h61 + i));
        set_line_limit(32'd3);
        send_key(8'h7A);
        send_key(8'h67);
        send_key(8'h68);
        set_line_limit(32'd1);
        send_key(CH_LF);
    endtask

    task automatic test_full_lines();
        set_line_limit(32'd256);
        send_key(CH_LF);
        for (int i = 0; i < MAX_LINE; i++)
            send_key(CHAR_W'($urandom_range(8'h80, 8'hFF)));
    endtask

    task automatic test_backpressure();
        set_line_limit(32'd16);
        send_idle_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 40; i++)
            send_key(pick_keystroke());
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            set_line_limit(pick_limit());
            for (int i = 0; i < 14; i++)
                send_key(pick_keystroke());
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_char = '0;
        line_count = 0;
        limit_reg = LIMIT_RESET;
        mismatches = 0;
        cycles = 0;
        hold_left = 0;
        send_idle_pct = 30;
        recv_idle_pct = 80;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edits();
        test_limit_extremes();
        test_random_traffic(30, 80);
        test_random_traffic(80, 30);
        test_random_traffic(0, 0);
        test_full_lines();
        test_backpressure();

        rx_ch.valid = 1'b0;
        waited = 0;
        while (results_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (5) @(negedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", results_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
